// ===== rtl/core/mlrf_pkg.sv =====
// Shared types, constants and the sRGB decode table of the luminance range fraction block.
`default_nettype none
package mlrf_pkg;

    localparam int COUNT_BITS = 20;
    localparam int OUT_BITS = 20;
    localparam int CNT_EXT = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [OUT_BITS-1:0] OUT_COUNT_MAX = {OUT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int CODE_W = 8;
    localparam int LIN_W = 25;
    localparam int WGT_W = 16;
    localparam int PROD_W = LIN_W + WGT_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int SCALED_W = SUM_W + 8;
    localparam int LEVEL_SHIFT = 40;
    localparam int FRAC_W = 17;
    localparam int DIV_STEPS = FRAC_W;
    localparam int STEP_W = 5;

    localparam logic [WGT_W-1:0] W_RED = 16'd13933;
    localparam logic [WGT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WGT_W-1:0] W_BLUE = 16'd4732;

    localparam logic [63:0] LIN_NUM = 64'd167772160;
    localparam logic [63:0] LIN_BIAS = 64'd16473;
    localparam logic [63:0] LIN_DEN = 64'd32946;
    localparam logic [63:0] GAM_DEN = 64'd269025;
    localparam logic [63:0] GAM_OFS = 64'd14025;
    localparam int Q31 = 31;

    localparam logic CFG_RANGE_LOW = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    typedef struct packed {
        logic masked;
        logic hit;
        logic last;
    } cls_t;

    typedef logic [255:0][LIN_W-1:0] lut_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] probe;
        n = value;
        root = 64'd0;
        probe = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= root + probe)
            begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [LIN_W-1:0] srgb_decode(input logic [63:0] code);
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] r;
        logic [63:0] lin;
        if (code < 64'd11)
        begin
            lin = (code * LIN_NUM + LIN_BIAS) / LIN_DEN;
        end
        else
        begin
            t = ((64'd1000 * code + GAM_OFS) << Q31) / GAM_DEN;
            acc = (t * t) >> Q31;
            r = t;
            for (int k = 1; k <= 24; k++)
            begin
                r = isqrt64(r << Q31);
                if ((k % 4) >= 2)
                begin
                    acc = (acc * r) >> Q31;
                end
            end
            lin = (acc + 64'd64) >> 7;
        end
        return lin[LIN_W-1:0];
    endfunction

    function automatic lut_t build_lut();
        lut_t lut;
        for (int c = 0; c < 256; c++)
        begin
            lut[c] = srgb_decode(64'(c));
        end
        return lut;
    endfunction

    localparam lut_t SRGB_LUT = build_lut();

endpackage
`default_nettype wire

// ===== rtl/core/mlrf_if.sv =====
// Handshake channels for pixel words and result words.
`default_nettype none
interface mlrf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       in_mask;
    logic       last_pixel;

    modport source (output valid, blue, green, red, in_mask, last_pixel, input ready);
    modport sink (input valid, blue, green, red, in_mask, last_pixel, output ready);
endinterface

interface mlrf_res_if;
    logic        valid;
    logic        ready;
    logic [16:0] score_fraction;
    logic [19:0] masked_pixels;
    logic        no_masked_pixels;

    modport source (output valid, score_fraction, masked_pixels, no_masked_pixels, input ready);
    modport sink (input valid, score_fraction, masked_pixels, no_masked_pixels, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/masked_luminance_range_fraction.sv =====
// Top level of the masked luminance range fraction block.
// Pixel words enter at one per cycle, unless pix.ready is low, into a four-stage front pipeline
// that decodes the sRGB codes through a constant table, weights them into luminance, rounds it
// to an 8-bit level and tests it against range_low..range_high; a four-word queue passes each
// classified word to the back end, which counts one word per cycle while it is in its counting
// state. The word marked last_pixel starts a restoring divider in the back end. The front
// pipeline keeps taking words of the next image while the queue has room, and the result waits
// in an output register until it is taken.
// The range registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while no image is in flight, and the block itself does not enforce this; index 0
// is range_low and index 1 is range_high.
`default_nettype none
module masked_luminance_range_fraction (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    mlrf_pix_if.sink        pix,
    mlrf_res_if.source      res
);

    mlrf_pkg::cls_t front_cls;
    logic           front_valid;
    logic           front_ready;
    mlrf_pkg::cls_t back_cls;
    logic           back_valid;
    logic           back_ready;

    mlrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .cls       (front_cls),
        .cls_valid (front_valid),
        .cls_ready (front_ready)
    );

    mlrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cls),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_cls),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    mlrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (back_cls),
        .cls_valid (back_valid),
        .cls_ready (back_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mlrf_front.sv =====
// Front pipeline: decodes pixels, forms the luminance level and classifies it against the range.
`default_nettype none
module mlrf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [7:0]     cfg_data,
    mlrf_pix_if.sink            pix,
    output mlrf_pkg::cls_t      cls,
    output logic                cls_valid,
    input  wire logic           cls_ready
);

    logic [7:0] range_low_reg;
    logic [7:0] range_high_reg;

    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s3_valid_reg;
    logic       s4_valid_reg;
    logic       s1_ready;
    logic       s2_ready;
    logic       s3_ready;
    logic       s4_ready;

    logic [mlrf_pkg::LIN_W-1:0]  s1_lin_r_reg;
    logic [mlrf_pkg::LIN_W-1:0]  s1_lin_g_reg;
    logic [mlrf_pkg::LIN_W-1:0]  s1_lin_b_reg;
    logic                        s1_mask_reg;
    logic                        s1_last_reg;
    logic [mlrf_pkg::PROD_W-1:0] s2_prod_r_reg;
    logic [mlrf_pkg::PROD_W-1:0] s2_prod_g_reg;
    logic [mlrf_pkg::PROD_W-1:0] s2_prod_b_reg;
    logic                        s2_mask_reg;
    logic                        s2_last_reg;
    logic [mlrf_pkg::SUM_W-1:0]  s3_sum_reg;
    logic                        s3_mask_reg;
    logic                        s3_last_reg;
    mlrf_pkg::cls_t              s4_cls_reg;

    logic [mlrf_pkg::SCALED_W-1:0] scaled;
    logic [mlrf_pkg::SCALED_W-1:0] rounded;
    logic [9:0]                    level_wide;
    logic [7:0]                    level;
    logic                          in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg <= 8'd0;
            range_high_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mlrf_pkg::CFG_RANGE_LOW)
            begin
                range_low_reg <= cfg_data;
            end
            else
            begin
                range_high_reg <= cfg_data;
            end
        end
    end

    assign s4_ready = !s4_valid_reg || cls_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pix.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // The level is floor(Y * 255 + 1/2) with Y in Q0.40, clipped to 255.
    assign scaled = {s3_sum_reg, 8'd0} - mlrf_pkg::SCALED_W'(s3_sum_reg);
    assign rounded = scaled + (mlrf_pkg::SCALED_W'(1) << (mlrf_pkg::LEVEL_SHIFT - 1));
    assign level_wide = rounded[mlrf_pkg::SCALED_W-1:mlrf_pkg::LEVEL_SHIFT];
    assign level = (level_wide > 10'd255) ? 8'd255 : level_wide[7:0];
    assign in_range = (level >= range_low_reg) && (level <= range_high_reg);

    always_ff @(posedge clk)
    begin
        if (s1_ready && pix.valid)
        begin
            s1_lin_r_reg <= mlrf_pkg::SRGB_LUT[pix.red];
            s1_lin_g_reg <= mlrf_pkg::SRGB_LUT[pix.green];
            s1_lin_b_reg <= mlrf_pkg::SRGB_LUT[pix.blue];
            s1_mask_reg <= pix.in_mask;
            s1_last_reg <= pix.last_pixel;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_r_reg <= mlrf_pkg::PROD_W'(s1_lin_r_reg) * mlrf_pkg::PROD_W'(mlrf_pkg::W_RED);
            s2_prod_g_reg <= mlrf_pkg::PROD_W'(s1_lin_g_reg)
                             * mlrf_pkg::PROD_W'(mlrf_pkg::W_GREEN);
            s2_prod_b_reg <= mlrf_pkg::PROD_W'(s1_lin_b_reg) * mlrf_pkg::PROD_W'(mlrf_pkg::W_BLUE);
            s2_mask_reg <= s1_mask_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sum_reg <= mlrf_pkg::SUM_W'(s2_prod_r_reg) + mlrf_pkg::SUM_W'(s2_prod_g_reg)
                          + mlrf_pkg::SUM_W'(s2_prod_b_reg);
            s3_mask_reg <= s2_mask_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_cls_reg.masked <= s3_mask_reg;
            s4_cls_reg.hit <= s3_mask_reg && in_range;
            s4_cls_reg.last <= s3_last_reg;
        end
    end

    assign cls = s4_cls_reg;
    assign cls_valid = s4_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mlrf_queue.sv =====
// Short queue of classified pixel words between the front pipeline and the counting back end.
`default_nettype none
module mlrf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mlrf_pkg::cls_t wr_data,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    output mlrf_pkg::cls_t      rd_data,
    output logic                rd_valid,
    input  wire logic           rd_ready
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    mlrf_pkg::cls_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;
    logic             push;
    logic             pop;

    assign wr_ready = (fill_reg != (PTR_W + 1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mlrf_back.sv =====
// Back end: saturating pixel counts, serial fraction divider and the result register.
`default_nettype none
module mlrf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mlrf_pkg::cls_t cls,
    input  wire logic           cls_valid,
    output logic                cls_ready,
    mlrf_res_if.source          res
);

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    localparam int CB = mlrf_pkg::COUNT_BITS;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CB-1:0] masked_reg;
    logic [CB-1:0] masked_next;
    logic [CB-1:0] inside_reg;
    logic [CB-1:0] inside_next;
    logic [CB-1:0] den_reg;
    logic [CB-1:0] rem_reg;
    logic [CB-1:0] rem_next;
    logic [mlrf_pkg::FRAC_W-1:0] quo_reg;
    logic [mlrf_pkg::FRAC_W-1:0] quo_next;
    logic [mlrf_pkg::STEP_W-1:0] step_reg;
    logic [mlrf_pkg::STEP_W-1:0] step_next;

    logic [CB:0]   trial;
    logic          fits;
    logic          take;
    logic [CB-1:0] cnt_m;
    logic [CB-1:0] cnt_i;

    logic                               out_valid_reg;
    logic [mlrf_pkg::FRAC_W-1:0]        frac_reg;
    logic [mlrf_pkg::OUT_BITS-1:0]      pixels_reg;
    logic                               empty_reg;
    logic                               out_load;
    logic [mlrf_pkg::CNT_EXT-1:0]       den_ext;
    logic [mlrf_pkg::OUT_BITS-1:0]      den_sat;

    assign cls_ready = (state_reg == ST_COUNT);
    assign take = cls_valid && cls_ready;

    // Counts including the word being taken now.
    assign cnt_m = (cls.masked && masked_reg != mlrf_pkg::COUNT_MAX) ? masked_reg + 1'b1
                                                                     : masked_reg;
    assign cnt_i = (cls.hit && inside_reg != mlrf_pkg::COUNT_MAX) ? inside_reg + 1'b1
                                                                  : inside_reg;

    // The first step tests the bare remainder; the rest shift a zero in first.
    assign trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits = (trial >= {1'b0, den_reg});

    assign den_ext = mlrf_pkg::CNT_EXT'(den_reg);
    assign den_sat = (den_ext > mlrf_pkg::CNT_EXT'(mlrf_pkg::OUT_COUNT_MAX))
                     ? mlrf_pkg::OUT_COUNT_MAX : den_ext[mlrf_pkg::OUT_BITS-1:0];

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        masked_next = masked_reg;
        inside_next = inside_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_COUNT:
            begin
                if (take)
                begin
                    if (cls.last)
                    begin
                        masked_next = '0;
                        inside_next = '0;
                        rem_next = cnt_i;
                        step_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        masked_next = cnt_m;
                        inside_next = cnt_i;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? CB'(trial - {1'b0, den_reg}) : CB'(trial);
                quo_next = {quo_reg[mlrf_pkg::FRAC_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == mlrf_pkg::STEP_W'(mlrf_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COUNT;
            masked_reg <= '0;
            inside_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            masked_reg <= masked_next;
            inside_reg <= inside_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        step_reg <= step_next;
        if (take && cls.last)
        begin
            den_reg <= cnt_m;
        end
        if (out_load)
        begin
            empty_reg <= (den_reg == '0);
            frac_reg <= (den_reg == '0) ? '0 : quo_reg;
            pixels_reg <= (den_reg == '0) ? '0 : den_sat;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.score_fraction = frac_reg;
    assign res.masked_pixels = pixels_reg;
    assign res.no_masked_pixels = empty_reg;

endmodule
`default_nettype wire
